[src/qrpid_pkg.sv]
// ============================================================================
// qrpid_pkg
// Shared widths, constants, types and helpers for the rate PID motor mixer.
// ============================================================================
package qrpid_pkg;

  // Fixed-point formats
  localparam int RATE_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int PROD_FRAC      = RATE_FRAC_BITS + GAIN_FRAC_BITS;

  // Field widths
  localparam int PULSE_W = 12;
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 48;
  localparam int MOTOR_W = 11;
  localparam int IN_W    = 4 * PULSE_W + 5 * ANGLE_W;
  localparam int OUT_W   = ((4 * MOTOR_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_AXES    = 3;
  localparam int NUM_MOTORS  = 4;
  localparam int AXIS_W      = 2;
  localparam int MOTOR_IDX_W = 2;

  // Internal widths
  localparam int SP_W    = 14;              // pulse minus dead band edge
  localparam int X_W     = 21;              // set point before the divide by three
  localparam int XA_W    = X_W - 1;         // magnitude of that value
  localparam int Q_W     = XA_W - 1;        // magnitude of the quotient
  localparam int E_W     = 20;              // error
  localparam int D_W     = E_W + 1;         // error difference
  localparam int MUL_W   = 22;              // multiplier operands
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 40;              // PID accumulation
  localparam int INTEG_W = 28;
  localparam int PID_W   = 26;
  localparam int MIX_W   = 30;

  // Divide by three as a multiply by a rounded-up reciprocal; exact below 2**XA_W
  localparam int DIV_SHIFT = XA_W + 2;
  localparam logic signed [MUL_W-1:0] DIV3_RECIP =
    MUL_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

  // Axis numbering
  localparam logic [AXIS_W-1:0] AX_YAW   = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AX_PITCH = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AX_ROLL  = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);
  localparam logic [MOTOR_IDX_W-1:0] LAST_MOTOR = MOTOR_IDX_W'(NUM_MOTORS - 1);

  // Stick and motor constants
  localparam logic [PULSE_W-1:0] DB_HIGH     = PULSE_W'(1508);
  localparam logic [PULSE_W-1:0] DB_LOW      = PULSE_W'(1492);
  localparam logic [PULSE_W-1:0] YAW_MIN_THR = PULSE_W'(1050);
  localparam logic [PULSE_W-1:0] STICK_LOW   = PULSE_W'(1012);
  localparam logic [PULSE_W-1:0] START_YAW   = PULSE_W'(1500);
  localparam logic [PULSE_W-1:0] STOP_YAW    = PULSE_W'(1988);
  localparam logic [MOTOR_W-1:0] MOTOR_STOP  = MOTOR_W'(1000);
  localparam logic [MOTOR_W-1:0] MOTOR_MIN   = MOTOR_W'(1100);
  localparam logic [MOTOR_W-1:0] MOTOR_MAX   = MOTOR_W'(2000);
  localparam logic signed [X_W-1:0] LEVEL_GAIN = X_W'(15);

  localparam logic signed [ACC_W-1:0] PID_LIMIT = ACC_W'(64'sd400 <<< PROD_FRAC);
  localparam logic signed [MIX_W-1:0] MIX_FLOOR = MIX_W'(64'sd1100 <<< PROD_FRAC);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    RUN_STOPPED  = 2'd0,
    RUN_STARTING = 2'd1,
    RUN_STARTED  = 2'd2
  } run_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARM, ST_SP, ST_DIV, ST_ERR, ST_MULP, ST_MULI,
    ST_INTEG, ST_ACCI, ST_PIDS, ST_MIX, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_ARM, OP_SETPT, OP_DIV, OP_ERR, OP_MULP,
    OP_MULI, OP_INTEG, OP_ACCI, OP_PIDS, OP_MIX, OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    logic [AXIS_W-1:0]       axis;
    logic [MOTOR_IDX_W-1:0]  motor;
  } dp_cmd_t;

  typedef struct packed {
    logic arm_started;   // start/stop machine is in started after this tick
    logic out_free;      // output register can take a new beat
  } dp_status_t;

  function automatic logic [GAIN_W-1:0] gain_pick(input logic [CFG_W-1:0] pack,
                                                  input logic [AXIS_W-1:0] axis);
    logic [GAIN_W-1:0] g;
    case (axis)
      AX_YAW:   g = pack[0 +: GAIN_W];
      AX_PITCH: g = pack[GAIN_W +: GAIN_W];
      AX_ROLL:  g = pack[2 * GAIN_W +: GAIN_W];
      default:  g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_pid(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > PID_LIMIT) r = PID_LIMIT;
    else if (v < -PID_LIMIT) r = -PID_LIMIT;
    else r = v;
    return r;
  endfunction

  // X mixing signs: bit 0 yaw, bit 1 pitch, bit 2 roll; a set bit subtracts
  function automatic logic [NUM_AXES-1:0] mix_neg(input logic [MOTOR_IDX_W-1:0] motor);
    logic [NUM_AXES-1:0] n;
    case (motor)
      2'd0:    n = 3'b110;   // front left
      2'd1:    n = 3'b011;   // front right
      2'd2:    n = 3'b101;   // rear left
      default: n = 3'b000;   // rear right
    endcase
    return n;
  endfunction

  function automatic logic [MOTOR_W-1:0] mix_out(input logic signed [MIX_W-1:0] v);
    logic [MIX_W-PROD_FRAC-1:0] q;
    logic [MOTOR_W-1:0]         r;
    q = v[MIX_W-1:PROD_FRAC];
    if (v < MIX_FLOOR) r = MOTOR_MIN;
    else if (q > (MIX_W-PROD_FRAC)'(MOTOR_MAX)) r = MOTOR_MAX;
    else r = q[MOTOR_W-1:0];
    return r;
  endfunction

endpackage

[src/qrpid_ctrl.sv]
// ============================================================================
// qrpid_ctrl
// Sequencer: walks the three axes through the shared multiplier, then mixes.
// ============================================================================
module qrpid_ctrl
  import qrpid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t             state, state_next;
  logic [AXIS_W-1:0]       axis, axis_next;
  logic [MOTOR_IDX_W-1:0]  motor, motor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
      motor <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      motor <= motor_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    motor_next = motor;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    cmd.motor  = motor;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_ARM;
        end
      end
      ST_ARM: begin
        cmd.op     = OP_ARM;
        axis_next  = '0;
        motor_next = '0;
        state_next = sts.arm_started ? ST_SP : ST_DONE;
      end
      ST_SP: begin
        cmd.op     = OP_SETPT;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op     = OP_DIV;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.op     = OP_ERR;
        state_next = ST_MULP;
      end
      ST_MULP: begin
        cmd.op     = OP_MULP;
        state_next = ST_MULI;
      end
      ST_MULI: begin
        cmd.op     = OP_MULI;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.op     = OP_INTEG;
        state_next = ST_ACCI;
      end
      ST_ACCI: begin
        cmd.op     = OP_ACCI;
        state_next = ST_PIDS;
      end
      ST_PIDS: begin
        cmd.op = OP_PIDS;
        if (axis == LAST_AXIS) begin
          state_next = ST_MIX;
        end else begin
          axis_next  = axis + AXIS_W'(1);
          state_next = ST_SP;
        end
      end
      ST_MIX: begin
        cmd.op = OP_MIX;
        if (motor == LAST_MOTOR) begin
          state_next = ST_DONE;
        end else begin
          motor_next = motor + MOTOR_IDX_W'(1);
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.op     = OP_LOAD;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/qrpid_dp.sv]
// ============================================================================
// qrpid_dp
// Datapath: gain registers, start/stop state, PID state, shared multiplier,
// mixer and output register.
// ============================================================================
module qrpid_dp
  import qrpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            sts,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_started
);

  // Gain registers
  logic [CFG_W-1:0] kp_gains, ki_gains, kd_gains;

  // Captured input beat
  logic        [PULSE_W-1:0] thr, yawp, pitp, rolp;
  logic signed [ANGLE_W-1:0] pang, rang;
  logic signed [ANGLE_W-1:0] rate [NUM_AXES];

  // Loop state
  run_t                      run_status, run_next;
  logic                      run_clear;
  logic signed [INTEG_W-1:0] integ [NUM_AXES];
  logic signed [E_W-1:0]     prev_err [NUM_AXES];
  logic signed [PID_W-1:0]   pid [NUM_AXES];

  // Working registers
  logic        [XA_W-1:0]    x_abs;
  logic                      x_neg;
  logic signed [E_W-1:0]     e_reg;
  logic signed [D_W-1:0]     d_reg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic        [MOTOR_W-1:0] motor_val [NUM_MOTORS];
  logic        [MOTOR_W-1:0] out_motor [NUM_MOTORS];

  // Combinational nets
  logic        [PULSE_W-1:0] sel_pulse;
  logic signed [ANGLE_W-1:0] sel_angle;
  logic signed [SP_W-1:0]    sp0;
  logic signed [X_W-1:0]     x_val;
  logic        [Q_W-1:0]     quot;
  logic signed [E_W-1:0]     sp_val;
  logic signed [E_W-1:0]     e_next;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   integ_sum, pid_sum;
  logic        [NUM_AXES-1:0] neg;
  logic signed [MIX_W-1:0]   thr_t, mix_sum;
  logic signed [MIX_W-1:0]   term [NUM_AXES];

  // ---------------------------------------------------------------- arming
  always_comb begin
    run_next  = run_status;
    run_clear = 1'b0;
    if (run_next == RUN_STOPPED && yawp <= STICK_LOW && thr <= STICK_LOW) begin
      run_next = RUN_STARTING;
    end
    if (run_next == RUN_STARTING && yawp == START_YAW && thr <= STICK_LOW) begin
      run_next  = RUN_STARTED;
      run_clear = 1'b1;
    end
    if (run_next == RUN_STARTED && yawp >= STOP_YAW && thr <= STICK_LOW) begin
      run_next = RUN_STOPPED;
    end
  end

  assign sts.arm_started = (run_next == RUN_STARTED);
  assign sts.out_free    = !out_valid || out_ready;

  // ------------------------------------------------------------- set point
  always_comb begin
    case (cmd.axis)
      AX_PITCH: begin
        sel_pulse = pitp;
        sel_angle = pang;
      end
      AX_ROLL: begin
        sel_pulse = rolp;
        sel_angle = rang;
      end
      default: begin
        sel_pulse = (thr > YAW_MIN_THR) ? yawp : START_YAW;  // centered: no yaw demand
        sel_angle = '0;
      end
    endcase
    if (sel_pulse > DB_HIGH) sp0 = signed'(SP_W'(sel_pulse)) - signed'(SP_W'(DB_HIGH));
    else if (sel_pulse < DB_LOW) sp0 = signed'(SP_W'(sel_pulse)) - signed'(SP_W'(DB_LOW));
    else sp0 = '0;
    x_val = (X_W'(sp0) <<< RATE_FRAC_BITS) - X_W'(sel_angle) * LEVEL_GAIN;
  end

  // --------------------------------------------------------------- error
  always_comb begin
    quot   = prod[DIV_SHIFT +: Q_W];
    sp_val = x_neg ? -signed'(E_W'(quot)) : signed'(E_W'(quot));
    e_next = E_W'(rate[cmd.axis]) - sp_val;
  end

  // ------------------------------------------------------ shared multiplier
  always_comb begin
    case (cmd.op)
      OP_DIV: begin
        mul_a = signed'(MUL_W'(x_abs));
        mul_b = DIV3_RECIP;
      end
      OP_MULP: begin
        mul_a = MUL_W'(e_reg);
        mul_b = signed'(MUL_W'(gain_pick(kp_gains, cmd.axis)));
      end
      OP_MULI: begin
        mul_a = MUL_W'(e_reg);
        mul_b = signed'(MUL_W'(gain_pick(ki_gains, cmd.axis)));
      end
      OP_INTEG: begin
        mul_a = MUL_W'(d_reg);
        mul_b = signed'(MUL_W'(gain_pick(kd_gains, cmd.axis)));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign integ_sum = ACC_W'(integ[cmd.axis]) + ACC_W'(prod);
  assign pid_sum   = acc + ACC_W'(integ[cmd.axis]);

  // ------------------------------------------------------------------ mixer
  always_comb begin
    neg   = mix_neg(cmd.motor);
    thr_t = signed'(MIX_W'(thr) << PROD_FRAC);
    for (int i = 0; i < NUM_AXES; i++) begin
      // below the idle throttle the PID terms drop out of the mix
      term[i] = (thr >= STICK_LOW) ? MIX_W'(pid[i]) : '0;
      if (neg[i]) term[i] = -term[i];
    end
    mix_sum = thr_t + term[0] + term[1] + term[2];
  end

  // --------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gains   <= '0;
      ki_gains   <= '0;
      kd_gains   <= '0;
      run_status <= RUN_STOPPED;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        integ[i]    <= '0;
        prev_err[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:  kp_gains <= cfg_data;
          REG_KI:  ki_gains <= cfg_data;
          REG_KD:  kd_gains <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ARM) begin
        run_status <= run_next;
        if (run_clear) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            integ[i]    <= '0;
            prev_err[i] <= '0;
          end
        end
      end
      if (cmd.op == OP_MULP) prev_err[cmd.axis] <= e_reg;
      if (cmd.op == OP_INTEG) integ[cmd.axis] <= INTEG_W'(clamp_pid(integ_sum));
      if (cmd.op == OP_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV || cmd.op == OP_MULP || cmd.op == OP_MULI ||
        cmd.op == OP_INTEG) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_CAPTURE: begin
        thr     <= in_data[0 +: PULSE_W];
        yawp    <= in_data[PULSE_W +: PULSE_W];
        pitp    <= in_data[2 * PULSE_W +: PULSE_W];
        rolp    <= in_data[3 * PULSE_W +: PULSE_W];
        pang    <= in_data[4 * PULSE_W +: ANGLE_W];
        rang    <= in_data[4 * PULSE_W + ANGLE_W +: ANGLE_W];
        rate[0] <= in_data[4 * PULSE_W + 2 * ANGLE_W +: ANGLE_W];
        rate[1] <= in_data[4 * PULSE_W + 3 * ANGLE_W +: ANGLE_W];
        rate[2] <= in_data[4 * PULSE_W + 4 * ANGLE_W +: ANGLE_W];
      end
      OP_SETPT: begin
        x_neg <= x_val[X_W-1];
        x_abs <= x_val[X_W-1] ? XA_W'(-x_val) : XA_W'(x_val);
      end
      OP_ERR:  e_reg <= e_next;
      OP_MULP: d_reg <= D_W'(e_reg) - D_W'(prev_err[cmd.axis]);
      OP_MULI: acc <= ACC_W'(prod);
      OP_ACCI: acc <= acc + ACC_W'(prod);
      OP_PIDS: pid[cmd.axis] <= PID_W'(clamp_pid(pid_sum));
      OP_MIX:  motor_val[cmd.motor] <= mix_out(mix_sum);
      OP_LOAD: begin
        out_started <= (run_status == RUN_STARTED);
        for (int m = 0; m < NUM_MOTORS; m++) begin
          out_motor[m] <= (run_status == RUN_STARTED) ? motor_val[m] : MOTOR_STOP;
        end
      end
      default: ;
    endcase
  end

  assign out_data = {(OUT_W - 4 * MOTOR_W)'(0), out_motor[3], out_motor[2],
                     out_motor[1], out_motor[0]};

endmodule

[src/quad_rate_pid_motor_mixer.sv]
// ============================================================================
// quad_rate_pid_motor_mixer
// Rate-mode PID loop with stick arming and X-frame four-motor mixing.
// ============================================================================
// Usage:
//   Send one beat per control tick on the s_axis group: four receiver pulses,
//   the pitch and roll angles and the three body rates. One result beat comes
//   back on the m_axis group with the four motor pulses in tdata and the
//   started flag in tuser.
//   Gains are written through cfg_we / cfg_index / cfg_data while the block
//   is idle: index 0 Kp, 1 Ki, 2 Kd, each three Q4.12 gains (yaw, pitch, roll).
// Timing:
//   A started tick arms, then runs each axis for 8 steps through the one
//   shared multiplier (divide by three, then the P, I and D products),
//   followed by 4 mixing steps, one per motor; a tick that leaves the block
//   stopped skips from arming to the result. The next beat is taken in the
//   cycle after the result is written into the output register, so a new
//   tick may start while an older result waits.
// Reset:
//   rst clears the gains, puts the arming machine in stopped, clears the
//   integral and previous-error state and empties the output register.
// Backpressure:
//   While m_axis_tready is low the result holds; a finished tick then waits
//   in the sequencer and s_axis_tready stays low.
module quad_rate_pid_motor_mixer
  import qrpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // throttle, yaw, pitch, roll pulses (12b each), pitch_angle, roll_angle,
  // rate_yaw, rate_pitch, rate_roll (16b each), lowest bit first
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // motor_a, motor_b, motor_c, motor_d (11b each), zero padding on top
  output logic [OUT_W-1:0]     m_axis_tdata,
  // is_started
  output logic                 m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer: one axis or motor step per cycle; a full output stalls it
  qrpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, loop state and the output register
  qrpid_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (s_axis_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata),
    .out_started (m_axis_tuser)
  );

  // A stopped result drives every motor at the stop pulse
  a_stopped_motors: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[0 +: MOTOR_W] == MOTOR_STOP &&
      m_axis_tdata[MOTOR_W +: MOTOR_W] == MOTOR_STOP &&
      m_axis_tdata[2 * MOTOR_W +: MOTOR_W] == MOTOR_STOP &&
      m_axis_tdata[3 * MOTOR_W +: MOTOR_W] == MOTOR_STOP)
    else $error("stopped beat with a running motor value");

  // A started result keeps the first and last motor inside the flight range
  a_started_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[0 +: MOTOR_W] >= MOTOR_MIN &&
      m_axis_tdata[0 +: MOTOR_W] <= MOTOR_MAX &&
      m_axis_tdata[3 * MOTOR_W +: MOTOR_W] >= MOTOR_MIN &&
      m_axis_tdata[3 * MOTOR_W +: MOTOR_W] <= MOTOR_MAX)
    else $error("started beat with a motor value outside the flight range");

  // One tick at a time: an accepted beat closes the input side
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a tick is in flight");

endmodule
